### design/msfs_pkg.sv
// ----------------------------------------------------------------------------
// msfs_pkg: shared types and constants of the multibyte separator field splitter
// Holds the payload structs, configuration register layout, register indexes
// and the partial-match fold helper used by the field matching core.
// ----------------------------------------------------------------------------
package msfs_pkg;

    // Separator and line geometry.
    localparam int MAX_SEP_BYTES  = 8;
    localparam int SEP_LEN_BITS   = 4;
    localparam int SEP_IDX_BITS   = 3;
    localparam int SEP_DATA_BITS  = 8 * MAX_SEP_BYTES;
    localparam int POS_BITS       = 16;
    localparam int FIELD_NUM_BITS = 10;

    localparam logic [POS_BITS-1:0]       POS_MAX       = {POS_BITS{1'b1}};
    localparam logic [FIELD_NUM_BITS-1:0] FIELD_NUM_MAX = {FIELD_NUM_BITS{1'b1}};
    localparam logic [7:0]                SPACE_BYTE    = 8'h20;

    // Configuration port layout and register indexes.
    localparam int CFG_IDX_BITS  = 2;
    localparam int CFG_DATA_BITS = SEP_DATA_BITS;

    localparam logic [CFG_IDX_BITS-1:0] CFG_SEP_BYTES  = 2'd0;
    localparam logic [CFG_IDX_BITS-1:0] CFG_SEP_LENGTH = 2'd1;
    localparam logic [CFG_IDX_BITS-1:0] CFG_TRIM       = 2'd2;

    localparam logic [SEP_DATA_BITS-1:0] RST_SEP_BYTES  = 64'd44;
    localparam logic [SEP_LEN_BITS-1:0]  RST_SEP_LENGTH = 4'd1;

    // One input transaction: a byte of the line.
    typedef struct packed {
        logic [7:0] data_byte;
        logic       line_end;
    } t_in;

    // One result transaction: a completed field.
    typedef struct packed {
        logic [15:0]               field_start;
        logic [15:0]               field_length;
        logic [FIELD_NUM_BITS-1:0] field_number;
        logic                      last_field;
        logic                      overflow;
    } t_out;

    // Configuration registers as seen by the core.
    typedef struct packed {
        logic [SEP_DATA_BITS-1:0] sep_bytes;
        logic [SEP_LEN_BITS-1:0]  sep_length;
        logic                     trim;
    } t_cfg;

    // Where the last non-space byte of a dropped partial match sits.
    typedef struct packed {
        logic                    found;
        logic [SEP_LEN_BITS-1:0] back;
    } t_fold;

    // Byte i of the separator word.
    function automatic logic [7:0] sep_byte(input logic [SEP_DATA_BITS-1:0] sep,
                                            input logic [SEP_IDX_BITS-1:0]  idx);
        sep_byte = sep[idx*8 +: 8];
    endfunction

    // For m matched bytes, find the last one that is not a space and return
    // how many bytes it lies before the end of the match.
    function automatic t_fold fold_info(input logic [SEP_DATA_BITS-1:0] sep,
                                        input logic [SEP_LEN_BITS-1:0]  m);
        t_fold res;
        res.found = 1'b0;
        res.back  = '0;
        for (int i = 1; i <= MAX_SEP_BYTES; i++) begin
            if ((SEP_LEN_BITS'(i) <= m) &&
                (sep[(i-1)*8 +: 8] != SPACE_BYTE)) begin
                res.found = 1'b1;
                res.back  = m - SEP_LEN_BITS'(i);
            end
        end
        fold_info = res;
    endfunction

endpackage

### design/msfs_core.sv
// ----------------------------------------------------------------------------
// msfs_core: separator matching and field bookkeeping
// Holds the per-line state and, for each stepped byte, produces zero, one or
// two completed fields in combinational logic.
// ----------------------------------------------------------------------------
module msfs_core (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_step,
    input  msfs_pkg::t_in    i_item,
    input  msfs_pkg::t_cfg   i_cfg,
    output logic [1:0]       o_count,
    output msfs_pkg::t_out   o_res0,
    output msfs_pkg::t_out   o_res1
);

    localparam int PB = msfs_pkg::POS_BITS;
    localparam int LB = msfs_pkg::SEP_LEN_BITS;

    // Line state.
    logic [PB-1:0]                       r_pos, n_pos;
    logic [PB-1:0]                       r_cfs, n_cfs;
    logic [LB-1:0]                       r_m, n_m;
    logic [PB-1:0]                       r_cen, n_cen;
    logic [msfs_pkg::FIELD_NUM_BITS-1:0] r_fc, n_fc;
    logic                                r_ovf, n_ovf;

    logic [LB-1:0]   len_eff;
    logic            at_max;
    logic [PB-1:0]   endp;
    logic            ovf_now;
    logic [LB-1:0]   m0, m1, m2;
    logic [7:0]      b;
    logic            mismatch;
    msfs_pkg::t_fold fold1, fold2;
    logic [PB-1:0]   cand1, cand2;
    logic [PB-1:0]   cen1, cen2, cen3;
    logic            hit, complete;
    logic [PB-1:0]   sstart_raw, sstart, end0, len0;
    logic [PB-1:0]   cfs2, end1, len1;
    logic [LB-1:0]   m3;
    logic [msfs_pkg::FIELD_NUM_BITS-1:0] fc2;

    // Effective separator length, clamped to 1..MAX_SEP_BYTES.
    always_comb begin
        if (i_cfg.sep_length == '0) begin
            len_eff = LB'(1);
        end else if (i_cfg.sep_length > LB'(msfs_pkg::MAX_SEP_BYTES)) begin
            len_eff = LB'(msfs_pkg::MAX_SEP_BYTES);
        end else begin
            len_eff = i_cfg.sep_length;
        end
    end

    // Match step, folds of dropped partial matches and field results.
    always_comb begin
        b       = i_item.data_byte;
        at_max  = (r_pos == msfs_pkg::POS_MAX);
        endp    = at_max ? r_pos : r_pos + PB'(1);
        ovf_now = r_ovf | at_max;
        m0      = (r_m >= len_eff) ? '0 : r_m;

        // A byte that breaks a partial match turns the match into content.
        mismatch = (m0 != '0) &&
                   (b != msfs_pkg::sep_byte(i_cfg.sep_bytes, m0[msfs_pkg::SEP_IDX_BITS-1:0]));
        fold1 = msfs_pkg::fold_info(i_cfg.sep_bytes, m0);
        cand1 = (r_pos >= PB'(fold1.back)) ? r_pos - PB'(fold1.back) : '0;
        cen1  = (mismatch && fold1.found && (cand1 > r_cen)) ? cand1 : r_cen;
        m1    = mismatch ? '0 : m0;

        // The byte is tested against the next separator byte.
        hit      = (b == msfs_pkg::sep_byte(i_cfg.sep_bytes, m1[msfs_pkg::SEP_IDX_BITS-1:0]));
        m2       = m1 + LB'(1);
        complete = hit && (m2 == len_eff);

        // Field closed by a completed separator.
        sstart_raw = (endp >= PB'(len_eff)) ? endp - PB'(len_eff) : '0;
        sstart     = (sstart_raw < r_cfs) ? r_cfs : sstart_raw;
        end0       = i_cfg.trim ? cen1 : sstart;
        len0       = (end0 > r_cfs) ? end0 - r_cfs : '0;

        cfs2 = r_cfs;
        fc2  = r_fc;
        cen2 = cen1;
        m3   = '0;
        if (complete) begin
            cfs2 = endp;
            cen2 = endp;
            if (r_fc != msfs_pkg::FIELD_NUM_MAX) begin
                fc2 = r_fc + msfs_pkg::FIELD_NUM_BITS'(1);
            end
        end else if (hit) begin
            m3 = m2;
        end else if (b != msfs_pkg::SPACE_BYTE) begin
            cen2 = endp;
        end

        // At line end a pending partial match is content of the final field.
        fold2 = msfs_pkg::fold_info(i_cfg.sep_bytes, m3);
        cand2 = (endp >= PB'(fold2.back)) ? endp - PB'(fold2.back) : '0;
        cen3  = ((m3 != '0) && fold2.found && (cand2 > cen2)) ? cand2 : cen2;
        end1  = i_cfg.trim ? cen3 : endp;
        len1  = (end1 > cfs2) ? end1 - cfs2 : '0;
    end

    // Result packing: the separator field always comes first.
    always_comb begin
        o_res1.field_start  = 16'(cfs2);
        o_res1.field_length = 16'(len1);
        o_res1.field_number = fc2;
        o_res1.last_field   = 1'b1;
        o_res1.overflow     = ovf_now;

        if (complete) begin
            o_res0.field_start  = 16'(r_cfs);
            o_res0.field_length = 16'(len0);
            o_res0.field_number = r_fc;
            o_res0.last_field   = 1'b0;
            o_res0.overflow     = ovf_now;
        end else begin
            o_res0 = o_res1;
        end

        o_count = {1'b0, complete} + {1'b0, i_item.line_end};
    end

    // Next line state; everything clears after the last byte of a line.
    always_comb begin
        if (i_item.line_end) begin
            n_pos = '0;
            n_cfs = '0;
            n_m   = '0;
            n_cen = '0;
            n_fc  = '0;
            n_ovf = 1'b0;
        end else begin
            n_pos = endp;
            n_cfs = cfs2;
            n_m   = m3;
            n_cen = cen2;
            n_fc  = fc2;
            n_ovf = ovf_now;
        end
    end

    // State registers advance once per stepped byte.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos <= '0;
            r_cfs <= '0;
            r_m   <= '0;
            r_cen <= '0;
            r_fc  <= '0;
            r_ovf <= 1'b0;
        end else if (i_step) begin
            r_pos <= n_pos;
            r_cfs <= n_cfs;
            r_m   <= n_m;
            r_cen <= n_cen;
            r_fc  <= n_fc;
            r_ovf <= n_ovf;
        end
    end

endmodule

### design/multibyte_separator_field_splitter.sv
// ----------------------------------------------------------------------------
// multibyte_separator_field_splitter: splits a text line into fields
// Input register, field matching core and a four-entry result queue.
// ----------------------------------------------------------------------------
// Usage:
// The input channel carries one byte of a line per transaction, with
// line_end set on the last byte. The output channel carries one transaction
// per completed field: start offset, length (optionally without trailing
// spaces), field index, a final-field flag and a sticky overflow flag.
// The separator (1 to 8 bytes), its length and the trim option are written
// through the configuration port; the user must do so only while no line
// data is in flight; the block does not enforce it. An accepted byte passes
// the input register and the result queue before its first field is output.
// One byte is taken every cycle while the queue has room for two results; a
// byte closing a separator on line end yields two fields, queued in order.
// Reset clears the line state and the queue and restores the default
// configuration: a single comma separator, no trimming.
// When the receiver stalls, the queue fills; once fewer than two entries
// are free the input register holds its byte and input ready drops.
// ----------------------------------------------------------------------------
module multibyte_separator_field_splitter (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  logic                                 i_in_valid,
    output logic                                 o_in_ready,
    input  msfs_pkg::t_in                        i_in_data,
    output logic                                 o_out_valid,
    input  logic                                 i_out_ready,
    output msfs_pkg::t_out                       o_out_data,
    input  logic                                 i_cfg_we,
    input  logic [msfs_pkg::CFG_IDX_BITS-1:0]    i_cfg_index,
    input  logic [msfs_pkg::CFG_DATA_BITS-1:0]   i_cfg_data
);

    localparam int QDEPTH = 4;
    localparam int QPB    = $clog2(QDEPTH);
    localparam int QCB    = QPB + 1;

    msfs_pkg::t_cfg r_cfg;
    msfs_pkg::t_in  r_in;
    logic           r_in_valid;
    logic           room;
    logic           step;
    logic           in_take;
    logic           pop;
    logic [1:0]     core_count;
    logic [1:0]     push_count;
    msfs_pkg::t_out res0, res1;

    msfs_pkg::t_out r_q [QDEPTH];
    logic [QPB-1:0] r_wr, r_rd;
    logic [QCB-1:0] r_qcount;

    // Configuration registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.sep_bytes  <= msfs_pkg::RST_SEP_BYTES;
            r_cfg.sep_length <= msfs_pkg::RST_SEP_LENGTH;
            r_cfg.trim       <= 1'b0;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                msfs_pkg::CFG_SEP_BYTES: begin
                    r_cfg.sep_bytes <= i_cfg_data;
                end
                msfs_pkg::CFG_SEP_LENGTH: begin
                    r_cfg.sep_length <= i_cfg_data[msfs_pkg::SEP_LEN_BITS-1:0];
                end
                msfs_pkg::CFG_TRIM: begin
                    r_cfg.trim <= i_cfg_data[0];
                end
                default: begin
                end
            endcase
        end
    end

    // Handshake: the core steps only when the queue can take two results.
    assign room       = (r_qcount <= QCB'(QDEPTH - 2));
    assign step       = r_in_valid && room;
    assign o_in_ready = !r_in_valid || room;
    assign in_take    = i_in_valid && o_in_ready;

    // Input register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else begin
            r_in_valid <= in_take || (r_in_valid && !step);
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_take) begin
            r_in <= i_in_data;
        end
    end

    // Field matching core.
    msfs_core u_core (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_step  (step),
        .i_item  (r_in),
        .i_cfg   (r_cfg),
        .o_count (core_count),
        .o_res0  (res0),
        .o_res1  (res1)
    );

    assign push_count = step ? core_count : 2'd0;
    assign pop        = o_out_valid && i_out_ready;

    // Result queue pointers and fill count.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr     <= '0;
            r_rd     <= '0;
            r_qcount <= '0;
        end else begin
            r_wr     <= r_wr + QPB'(push_count);
            r_rd     <= r_rd + QPB'(pop);
            r_qcount <= r_qcount + QCB'(push_count) - QCB'(pop);
        end
    end

    // Result queue entries; a second result goes to the slot after the first.
    always_ff @(posedge i_clk) begin
        if (push_count != 2'd0) begin
            r_q[r_wr] <= res0;
        end
        if (push_count == 2'd2) begin
            r_q[r_wr + QPB'(1)] <= res1;
        end
    end

    assign o_out_valid = (r_qcount != '0);
    assign o_out_data  = r_q[r_rd];

endmodule
